// ===== rtl/core/nsps_pkg.sv =====
// ----------------------------------------------------------------------------
// nsps_pkg
// Shared constants, types and command/status bundles for the nearest
// segment point search block.
// ----------------------------------------------------------------------------
package nsps_pkg;

  // Table and coordinate sizing.
  localparam int MAX_SEGMENTS = 64;
  localparam int COORD_BITS   = 20;
  localparam int SLOT_W       = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
  localparam int SLOT_FIELD_W = 6;
  localparam int CMD_W        = 2;
  localparam int WEIGHT_W     = 8;
  localparam int PROD_W       = 2 * COORD_BITS;
  localparam int SCORE_W      = PROD_W + WEIGHT_W + 1;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 8'd50;

  // Item command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE  = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_e;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_LOAD,
    ST_MUL,
    ST_DIVST,
    ST_DIV,
    ST_NY,
    ST_SQ,
    ST_WGT,
    ST_CMP,
    ST_NEXT,
    ST_DONE
  } state_e;

  // One stored segment.
  typedef struct packed {
    logic signed [COORD_BITS-1:0] sx;
    logic signed [COORD_BITS-1:0] sy;
    logic signed [COORD_BITS-1:0] ex;
    logic signed [COORD_BITS-1:0] ey;
  } seg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic tbl_write;
    logic tbl_remove;
    logic query_init;
    logic load;
    logic mul;
    logic div_start;
    logic ny;
    logic sq;
    logic wgt;
    logic cmp;
    logic idx_inc;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic cur_valid;
    logic last;
    logic div_done;
  } dp_status_t;

endpackage

// ===== rtl/core/nsps_div.sv =====
// ----------------------------------------------------------------------------
// nsps_div
// Restoring divider, one quotient bit per cycle. The dividend must be
// below divisor * 2^COORD_BITS, so the quotient fits in COORD_BITS bits.
// ----------------------------------------------------------------------------
module nsps_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [nsps_pkg::PROD_W-1:0]         dividend_i,
  input  logic [nsps_pkg::COORD_BITS-1:0]     divisor_i,
  output logic [nsps_pkg::COORD_BITS-1:0]     quotient_o,
  output logic                                done_o
);

  localparam int CW    = nsps_pkg::COORD_BITS;
  localparam int STP_W = $clog2(CW + 1);

  logic [CW-1:0]    rem_q, rem_d;
  logic [CW-1:0]    sh_q, sh_d;
  logic [CW-1:0]    dvs_q;
  logic [STP_W-1:0] cnt_q;
  logic             run_q;
  logic             done_q;
  logic [CW:0]      trial;
  logic             ge;

  // One shift-subtract step.
  always_comb begin
    trial = {rem_q, sh_q[CW-1]};
    ge    = trial >= {1'b0, dvs_q};
    rem_d = ge ? CW'(trial - {1'b0, dvs_q}) : trial[CW-1:0];
    sh_d  = {sh_q[CW-2:0], ge};
  end

  // Step control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= STP_W'(CW);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == STP_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient shift register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[2*CW-1:CW];
      sh_q  <= dividend_i[CW-1:0];
      dvs_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= rem_d;
      sh_q  <= sh_d;
    end
  end

  assign quotient_o = sh_q;
  assign done_o     = done_q;

endmodule

// ===== rtl/core/nsps_ctrl.sv =====
// ----------------------------------------------------------------------------
// nsps_ctrl
// Sequencer for the block: takes words in idle and walks a query over
// every table slot, one projection and score at a time.
// ----------------------------------------------------------------------------
module nsps_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [nsps_pkg::CMD_W-1:0]    cmd_i,
  input  nsps_pkg::dp_status_t          status_i,
  output nsps_pkg::dp_cmd_t             cmd_o,
  output logic                          busy_o,
  output logic                          done_o
);

  nsps_pkg::state_e st_q, st_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= nsps_pkg::ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // Next state.
  always_comb begin
    st_d = st_q;
    case (st_q)
      nsps_pkg::ST_IDLE: begin
        if (start_i && cmd_i == nsps_pkg::CMD_QUERY) begin
          st_d = status_i.empty ? nsps_pkg::ST_DONE : nsps_pkg::ST_FETCH;
        end
      end
      nsps_pkg::ST_FETCH: begin
        st_d = status_i.cur_valid ? nsps_pkg::ST_LOAD : nsps_pkg::ST_NEXT;
      end
      nsps_pkg::ST_LOAD:  st_d = nsps_pkg::ST_MUL;
      nsps_pkg::ST_MUL:   st_d = nsps_pkg::ST_DIVST;
      nsps_pkg::ST_DIVST: st_d = nsps_pkg::ST_DIV;
      nsps_pkg::ST_DIV: begin
        if (status_i.div_done) begin
          st_d = nsps_pkg::ST_NY;
        end
      end
      nsps_pkg::ST_NY:    st_d = nsps_pkg::ST_SQ;
      nsps_pkg::ST_SQ:    st_d = nsps_pkg::ST_WGT;
      nsps_pkg::ST_WGT:   st_d = nsps_pkg::ST_CMP;
      nsps_pkg::ST_CMP:   st_d = nsps_pkg::ST_NEXT;
      nsps_pkg::ST_NEXT: begin
        st_d = status_i.last ? nsps_pkg::ST_DONE : nsps_pkg::ST_FETCH;
      end
      nsps_pkg::ST_DONE:  st_d = nsps_pkg::ST_IDLE;
      default:            st_d = nsps_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    done_o = 1'b0;
    case (st_q)
      nsps_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          case (cmd_i)
            nsps_pkg::CMD_WRITE:  cmd_o.tbl_write  = 1'b1;
            nsps_pkg::CMD_REMOVE: cmd_o.tbl_remove = 1'b1;
            nsps_pkg::CMD_QUERY:  cmd_o.query_init = 1'b1;
            default:              cmd_o = '0;
          endcase
        end
      end
      nsps_pkg::ST_LOAD:  cmd_o.load      = 1'b1;
      nsps_pkg::ST_MUL:   cmd_o.mul       = 1'b1;
      nsps_pkg::ST_DIVST: cmd_o.div_start = 1'b1;
      nsps_pkg::ST_NY:    cmd_o.ny        = 1'b1;
      nsps_pkg::ST_SQ:    cmd_o.sq        = 1'b1;
      nsps_pkg::ST_WGT:   cmd_o.wgt       = 1'b1;
      nsps_pkg::ST_CMP:   cmd_o.cmp       = 1'b1;
      nsps_pkg::ST_NEXT:  cmd_o.idx_inc   = !status_i.last;
      nsps_pkg::ST_DONE:  done_o          = 1'b1;
      default:            cmd_o = '0;
    endcase
  end

`ifndef SYNTHESIS
  // A result strobe lasts one cycle and returns the block to idle.
  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o)
    else $error("result strobe not followed by idle");

  // An accepted query always makes the block busy.
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && cmd_i == nsps_pkg::CMD_QUERY) |=> busy_o)
    else $error("query accepted without going busy");

  // The divider completes only while the sequencer waits on it.
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.div_done |-> st_q == nsps_pkg::ST_DIV)
    else $error("divider finished outside its wait state");
`endif

endmodule

// ===== rtl/core/nsps_dp.sv =====
// ----------------------------------------------------------------------------
// nsps_dp
// Datapath: segment table, weight register, projection, divider and
// score compare with the running best.
// ----------------------------------------------------------------------------
module nsps_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  nsps_pkg::dp_cmd_t                     cmd_i,
  output nsps_pkg::dp_status_t                  status_o,
  input  logic                                  weight_we_i,
  input  logic [nsps_pkg::WEIGHT_W-1:0]         weight_i,
  input  logic [nsps_pkg::SLOT_FIELD_W-1:0]     slot_i,
  input  logic signed [nsps_pkg::COORD_BITS-1:0] start_x_i,
  input  logic signed [nsps_pkg::COORD_BITS-1:0] start_y_i,
  input  logic signed [nsps_pkg::COORD_BITS-1:0] end_x_i,
  input  logic signed [nsps_pkg::COORD_BITS-1:0] end_y_i,
  input  logic signed [nsps_pkg::COORD_BITS-1:0] point_x_i,
  input  logic signed [nsps_pkg::COORD_BITS-1:0] point_y_i,
  output logic                                  found_o,
  output logic [nsps_pkg::SLOT_FIELD_W-1:0]     best_slot_o,
  output logic signed [nsps_pkg::COORD_BITS-1:0] near_x_o,
  output logic signed [nsps_pkg::COORD_BITS-1:0] near_y_o
);

  localparam int CW  = nsps_pkg::COORD_BITS;
  localparam int NS  = nsps_pkg::MAX_SEGMENTS;
  localparam int SW  = nsps_pkg::SLOT_W;
  localparam int PW  = nsps_pkg::PROD_W;
  localparam int SCW = nsps_pkg::SCORE_W;
  localparam int WW  = nsps_pkg::WEIGHT_W;

  // Table storage.
  nsps_pkg::seg_t mem_q [NS];
  nsps_pkg::seg_t rd_q;
  logic [NS-1:0]  valid_q;
  logic [nsps_pkg::CNT_W-1:0] count_q;
  logic [WW-1:0]  weight_q;
  logic [SW-1:0]  idx_q;
  logic           slot_ok;
  logic [SW-1:0]  wslot;

  // Query point and per-slot pipeline registers.
  logic signed [CW-1:0] px_q, py_q;
  logic signed [CW-1:0] cx_q, sy_q, vy_q, ny_q;
  logic [CW-1:0]        am_q, bm_q, cm_q, dx_q, dy_q;
  logic                 neg_q, vert_q;
  logic [PW-1:0]        prod_q, dx2_q, dy2_q;
  logic [PW+WW-1:0]     wx_q;

  // Running best.
  logic                 found_q;
  logic [SCW-1:0]       best_q;
  logic [SW-1:0]        bslot_q;
  logic signed [CW-1:0] bx_q, by_q;

  // Combinational helpers.
  logic signed [CW-1:0] lox, hix, loy, hiy, cx, vy, ny;
  logic signed [CW:0]   da, db, dc, ddx, ddy, nyw;
  logic [CW-1:0]        quot;
  logic                 div_done;
  logic [SCW-1:0]       score;

  assign slot_ok = int'(slot_i) < NS;
  assign wslot   = slot_i[SW-1:0];

  // Table write port and registered read of the current slot.
  always_ff @(posedge clk_i) begin
    if (cmd_i.tbl_write && slot_ok) begin
      mem_q[wslot] <= '{sx: start_x_i, sy: start_y_i, ex: end_x_i, ey: end_y_i};
    end
    rd_q <= mem_q[idx_q];
  end

  // Valid bits, count, weight and slot index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      count_q  <= '0;
      weight_q <= nsps_pkg::WEIGHT_RESET;
      idx_q    <= '0;
    end else begin
      if (weight_we_i) begin
        weight_q <= weight_i;
      end
      if (cmd_i.tbl_write && slot_ok) begin
        valid_q[wslot] <= 1'b1;
        if (!valid_q[wslot]) begin
          count_q <= count_q + 1'b1;
        end
      end else if (cmd_i.tbl_remove && slot_ok && valid_q[wslot]) begin
        valid_q[wslot] <= 1'b0;
        count_q        <= count_q - 1'b1;
      end
      if (cmd_i.query_init) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  // Clamp x and y to the segment's spans and set up the line interpolation.
  always_comb begin
    lox = (rd_q.sx < rd_q.ex) ? rd_q.sx : rd_q.ex;
    hix = (rd_q.sx < rd_q.ex) ? rd_q.ex : rd_q.sx;
    loy = (rd_q.sy < rd_q.ey) ? rd_q.sy : rd_q.ey;
    hiy = (rd_q.sy < rd_q.ey) ? rd_q.ey : rd_q.sy;
    cx  = (px_q < lox) ? lox : ((px_q > hix) ? hix : px_q);
    vy  = (py_q < loy) ? loy : ((py_q > hiy) ? hiy : py_q);
    da  = {cx[CW-1], cx} - {rd_q.sx[CW-1], rd_q.sx};
    db  = {rd_q.ey[CW-1], rd_q.ey} - {rd_q.sy[CW-1], rd_q.sy};
    dc  = {rd_q.ex[CW-1], rd_q.ex} - {rd_q.sx[CW-1], rd_q.sx};
  end

  // y on the line, then distances to the query point.
  always_comb begin
    nyw = neg_q ? ({sy_q[CW-1], sy_q} - {1'b0, quot})
                : ({sy_q[CW-1], sy_q} + {1'b0, quot});
    ny  = vert_q ? vy_q : nyw[CW-1:0];
    ddx = {cx_q[CW-1], cx_q} - {px_q[CW-1], px_q};
    ddy = {ny[CW-1], ny} - {py_q[CW-1], py_q};
  end

  assign score = SCW'(wx_q) + SCW'(dy2_q);

  // Per-slot pipeline.
  always_ff @(posedge clk_i) begin
    if (cmd_i.query_init) begin
      px_q <= point_x_i;
      py_q <= point_y_i;
    end
    if (cmd_i.load) begin
      cx_q   <= cx;
      vy_q   <= vy;
      sy_q   <= rd_q.sy;
      am_q   <= da[CW] ? CW'(-da) : da[CW-1:0];
      bm_q   <= db[CW] ? CW'(-db) : db[CW-1:0];
      cm_q   <= dc[CW] ? CW'(-dc) : dc[CW-1:0];
      neg_q  <= da[CW] ^ db[CW] ^ dc[CW];
      vert_q <= (rd_q.ex == rd_q.sx);
    end
    if (cmd_i.mul) begin
      prod_q <= am_q * bm_q;
    end
    if (cmd_i.ny) begin
      ny_q <= ny;
      dx_q <= ddx[CW] ? CW'(-ddx) : ddx[CW-1:0];
      dy_q <= ddy[CW] ? CW'(-ddy) : ddy[CW-1:0];
    end
    if (cmd_i.sq) begin
      dx2_q <= dx_q * dx_q;
      dy2_q <= dy_q * dy_q;
    end
    if (cmd_i.wgt) begin
      wx_q <= dx2_q * weight_q;
    end
  end

  // Running best; cleared at query start so an empty table reports zeros.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      best_q  <= '0;
      bslot_q <= '0;
      bx_q    <= '0;
      by_q    <= '0;
    end else if (cmd_i.query_init) begin
      found_q <= 1'b0;
      best_q  <= '0;
      bslot_q <= '0;
      bx_q    <= '0;
      by_q    <= '0;
    end else if (cmd_i.cmp && (!found_q || score < best_q)) begin
      found_q <= 1'b1;
      best_q  <= score;
      bslot_q <= idx_q;
      bx_q    <= cx_q;
      by_q    <= ny_q;
    end
  end

  nsps_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (prod_q),
    .divisor_i  (cm_q),
    .quotient_o (quot),
    .done_o     (div_done)
  );

  always_comb begin
    status_o.empty     = (count_q == '0);
    status_o.cur_valid = valid_q[idx_q];
    status_o.last      = (idx_q == SW'(NS - 1));
    status_o.div_done  = div_done;
  end

  assign found_o     = found_q;
  assign best_slot_o = nsps_pkg::SLOT_FIELD_W'(bslot_q);
  assign near_x_o    = bx_q;
  assign near_y_o    = by_q;

`ifndef SYNTHESIS
  // The live count always matches the number of valid slots.
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(count_q))
    else $error("valid count out of step with valid bits");
`endif

endmodule

// ===== rtl/core/nearest_segment_point_search.sv =====
// ----------------------------------------------------------------------------
// nearest_segment_point_search
// Segment table with nearest-point query by weighted squared distance.
// ----------------------------------------------------------------------------
// Usage: a word is taken at a clock edge where start_i is high and busy_o
// is low. cmd_i selects write segment (slot_i, start/end coordinates),
// remove segment (slot_i) or query (point_x_i, point_y_i). Write and
// remove finish in the cycle they are taken and give no result, so the
// next word may follow in the next cycle. A query gives one result word
// on found_o, best_slot_o, near_x_o, near_y_o, marked by done_o for one
// cycle; the receiver cannot stall it. A query visits each slot: empty
// slots are skipped; a valid one is loaded, multiplied, divided by the
// one-bit-per-cycle divider for the line interpolation, squared, weighted
// and compared. An empty table goes straight to the result. x_weight_i
// is written when x_weight_we_i is high, only while the block is idle;
// the user must ensure this, not the block. Reset clears all valid
// bits and sets the weight to 50; segment storage is not cleared.
// ----------------------------------------------------------------------------
module nearest_segment_point_search (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  output logic                                   busy_o,
  input  logic                                   x_weight_we_i,
  input  logic [nsps_pkg::WEIGHT_W-1:0]          x_weight_i,
  input  logic [nsps_pkg::CMD_W-1:0]             cmd_i,
  input  logic [nsps_pkg::SLOT_FIELD_W-1:0]      slot_i,
  input  logic signed [nsps_pkg::COORD_BITS-1:0] start_x_i,
  input  logic signed [nsps_pkg::COORD_BITS-1:0] start_y_i,
  input  logic signed [nsps_pkg::COORD_BITS-1:0] end_x_i,
  input  logic signed [nsps_pkg::COORD_BITS-1:0] end_y_i,
  input  logic signed [nsps_pkg::COORD_BITS-1:0] point_x_i,
  input  logic signed [nsps_pkg::COORD_BITS-1:0] point_y_i,
  output logic                                   done_o,
  output logic                                   found_o,
  output logic [nsps_pkg::SLOT_FIELD_W-1:0]      best_slot_o,
  output logic signed [nsps_pkg::COORD_BITS-1:0] near_x_o,
  output logic signed [nsps_pkg::COORD_BITS-1:0] near_y_o
);

  nsps_pkg::dp_cmd_t    dp_cmd;
  nsps_pkg::dp_status_t dp_status;

  nsps_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .cmd_i    (cmd_i),
    .status_i (dp_status),
    .cmd_o    (dp_cmd),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  nsps_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .status_o    (dp_status),
    .weight_we_i (x_weight_we_i),
    .weight_i    (x_weight_i),
    .slot_i      (slot_i),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .point_x_i   (point_x_i),
    .point_y_i   (point_y_i),
    .found_o     (found_o),
    .best_slot_o (best_slot_o),
    .near_x_o    (near_x_o),
    .near_y_o    (near_y_o)
  );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the nearest segment point search block. A directed
// table of words comes first (empty table, extreme coordinates, vertical
// segments, ties, ignored commands), then random words in several x_weight
// phases. Every query result is compared with the given values of a typed
// row, else with a model of the segment table kept inside the bench.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [nsps_pkg::CMD_W-1:0] CMD_IGNORED = 2'd3;
  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 50;

  typedef logic signed [nsps_pkg::COORD_BITS-1:0] coord_t;

  typedef struct {
    logic                              found;
    logic [nsps_pkg::SLOT_FIELD_W-1:0] slot;
    coord_t                            nx;
    coord_t                            ny;
  } nearest_t;

  typedef struct {
    logic [nsps_pkg::CMD_W-1:0]        cmd;
    logic [nsps_pkg::SLOT_FIELD_W-1:0] slot;
    coord_t                            sx, sy, ex, ey, px, py;
    bit                                typed;
    nearest_t                          want;
  } row_t;

  logic clk_i, rst_ni;
  logic start_i, busy_o, x_weight_we_i;
  logic [nsps_pkg::WEIGHT_W-1:0] x_weight_i;
  logic [nsps_pkg::CMD_W-1:0] cmd_i;
  logic [nsps_pkg::SLOT_FIELD_W-1:0] slot_i;
  coord_t start_x_i, start_y_i, end_x_i, end_y_i, point_x_i, point_y_i;
  logic done_o, found_o;
  logic [nsps_pkg::SLOT_FIELD_W-1:0] best_slot_o;
  coord_t near_x_o, near_y_o;

  // Model of the segment table and weight.
  bit     tbl_valid [nsps_pkg::MAX_SEGMENTS];
  coord_t tbl_sx [nsps_pkg::MAX_SEGMENTS], tbl_sy [nsps_pkg::MAX_SEGMENTS];
  coord_t tbl_ex [nsps_pkg::MAX_SEGMENTS], tbl_ey [nsps_pkg::MAX_SEGMENTS];
  logic [nsps_pkg::WEIGHT_W-1:0] model_weight;

  nearest_t pending_nearest[$];
  row_t     directed_rows[$];
  int       error_count;
  int       idle_cycles;

  nearest_segment_point_search i_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .x_weight_we_i, .x_weight_i,
    .cmd_i, .slot_i, .start_x_i, .start_y_i, .end_x_i, .end_y_i,
    .point_x_i, .point_y_i, .done_o, .found_o, .best_slot_o,
    .near_x_o, .near_y_o
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Closest point on one stored segment to the query point.
  task automatic project_point(input int i, input longint px, input longint py,
                               output longint nx, output longint ny);
    longint sx, sy, ex, ey, lo, hi, a, b, c;
    longint unsigned q;
    bit neg;
    sx = tbl_sx[i]; sy = tbl_sy[i]; ex = tbl_ex[i]; ey = tbl_ey[i];
    lo = (sx < ex) ? sx : ex;
    hi = (sx < ex) ? ex : sx;
    nx = (px < lo) ? lo : ((px > hi) ? hi : px);
    if (ex == sx) begin
      lo = (sy < ey) ? sy : ey;
      hi = (sy < ey) ? ey : sy;
      ny = (py < lo) ? lo : ((py > hi) ? hi : py);
    end else begin
      a = nx - sx; b = ey - sy; c = ex - sx;
      q = ((a < 0 ? -a : a) * (b < 0 ? -b : b)) / (c < 0 ? -c : c);
      neg = ((a < 0) ^ (b < 0)) ^ (c < 0);
      if (a == 0 || b == 0) neg = 1'b0;
      ny = neg ? sy - longint'(q) : sy + longint'(q);
    end
  endtask

  // Applies one accepted word to the model; returns 1 with the nearest
  // point when the word is a query.
  task automatic apply_word(input row_t w, output bit has_result,
                            output nearest_t res);
    longint nx, ny, dx, dy, bx, by;
    longint unsigned score, best_score;
    int best;
    has_result = 1'b0;
    res = '{1'b0, '0, '0, '0};
    case (w.cmd)
      nsps_pkg::CMD_WRITE: begin
        tbl_valid[w.slot] = 1'b1;
        tbl_sx[w.slot] = w.sx; tbl_sy[w.slot] = w.sy;
        tbl_ex[w.slot] = w.ex; tbl_ey[w.slot] = w.ey;
      end
      nsps_pkg::CMD_REMOVE: tbl_valid[w.slot] = 1'b0;
      nsps_pkg::CMD_QUERY: begin
        has_result = 1'b1;
        best = -1;
        best_score = 0;
        bx = 0; by = 0;
        for (int i = 0; i < nsps_pkg::MAX_SEGMENTS; i++) begin
          if (tbl_valid[i]) begin
            project_point(i, w.px, w.py, nx, ny);
            dx = nx - w.px; dy = ny - w.py;
            score = longint'(dx * dx) * model_weight + longint'(dy * dy);
            if (best < 0 || score < best_score) begin
              best = i; best_score = score; bx = nx; by = ny;
            end
          end
        end
        if (best >= 0) begin
          res = '{1'b1, best[nsps_pkg::SLOT_FIELD_W-1:0], coord_t'(bx), coord_t'(by)};
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string field, input longint got,
                                 input longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    error_count++;
  endtask

  // Drives one word and holds it until the block takes it.
  task automatic send_word(input row_t w);
    bit has_result;
    nearest_t res;
    start_i   <= 1'b1;
    cmd_i     <= w.cmd;     slot_i    <= w.slot;
    start_x_i <= w.sx;      start_y_i <= w.sy;
    end_x_i   <= w.ex;      end_y_i   <= w.ey;
    point_x_i <= w.px;      point_y_i <= w.py;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    apply_word(w, has_result, res);
    if (has_result) pending_nearest.push_back(w.typed ? w.want : res);
  endtask

  // Lowers start and waits out every result before a register write.
  task automatic drain_results();
    start_i <= 1'b0;
    while (pending_nearest.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic write_weight(input logic [nsps_pkg::WEIGHT_W-1:0] w);
    drain_results();
    x_weight_we_i <= 1'b1;
    x_weight_i    <= w;
    model_weight   = w;
    @(posedge clk_i);
    x_weight_we_i <= 1'b0;
  endtask

  task automatic add_row(input logic [nsps_pkg::CMD_W-1:0] cmd, input int slot,
                         input int sx, input int sy, input int ex, input int ey,
                         input int px, input int py, input bit typed,
                         input bit f, input int bs, input int nx, input int ny);
    row_t r;
    r.cmd = cmd; r.slot = nsps_pkg::SLOT_FIELD_W'(slot);
    r.sx = coord_t'(sx); r.sy = coord_t'(sy);
    r.ex = coord_t'(ex); r.ey = coord_t'(ey);
    r.px = coord_t'(px); r.py = coord_t'(py);
    r.typed = typed;
    r.want = '{f, bs[nsps_pkg::SLOT_FIELD_W-1:0], coord_t'(nx), coord_t'(ny)};
    directed_rows.push_back(r);
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 3))
      0: return coord_t'($urandom);
      1: case ($urandom_range(0, 3))
           0: return coord_t'(-524288);
           1: return coord_t'(524287);
           2: return coord_t'(0);
           default: return coord_t'(-1);
         endcase
      default: return coord_t'(int'($urandom_range(0, 400)) - 200);
    endcase
  endfunction

  function automatic row_t rand_word();
    row_t r;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) r.cmd = nsps_pkg::CMD_WRITE;
    else if (pick < 65) r.cmd = nsps_pkg::CMD_REMOVE;
    else if (pick < 95) r.cmd = nsps_pkg::CMD_QUERY;
    else r.cmd = CMD_IGNORED;
    r.slot = nsps_pkg::SLOT_FIELD_W'($urandom_range(0, 63));
    r.sx = rand_coord(); r.sy = rand_coord();
    r.ex = ($urandom_range(0, 9) == 0) ? r.sx : rand_coord();
    r.ey = rand_coord();
    r.px = rand_coord(); r.py = rand_coord();
    r.typed = 1'b0;
    r.want = '{1'b0, '0, '0, '0};
    return r;
  endfunction

  // Result checker.
  always @(posedge clk_i) begin
    nearest_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_nearest.size() == 0) begin
        $display("%0t: result word with nothing expected", $time);
        error_count++;
      end else begin
        want = pending_nearest.pop_front();
        if (found_o !== want.found) report_mismatch("found", found_o, want.found);
        if (best_slot_o !== want.slot) report_mismatch("best_slot", best_slot_o, want.slot);
        if (near_x_o !== want.nx) report_mismatch("near_x", near_x_o, want.nx);
        if (near_y_o !== want.ny) report_mismatch("near_y", near_y_o, want.ny);
      end
    end
  end

  // Watchdog on cycles in which no word moves either way.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && busy_o === 1'b0) || done_o === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus.
  initial begin
    logic [nsps_pkg::WEIGHT_W-1:0] phase_weight [5];
    error_count = 0;
    idle_cycles = 0;
    model_weight = nsps_pkg::WEIGHT_RESET;
    foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
    rst_ni = 1'b0; start_i = 1'b0; x_weight_we_i = 1'b0; x_weight_i = '0;
    cmd_i = nsps_pkg::CMD_WRITE; slot_i = '0;
    start_x_i = '0; start_y_i = '0; end_x_i = '0; end_y_i = '0;
    point_x_i = '0; point_y_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table, full-range diagonal, vertical clamp, tie, ignored words.
    add_row(nsps_pkg::CMD_QUERY, 0, 0, 0, 0, 0, 5, 5, 1, 0, 0, 0, 0);
    add_row(nsps_pkg::CMD_WRITE, 5, -524288, -524288, 524287, 524287, 0, 0, 0, 0, 0, 0, 0);
    add_row(nsps_pkg::CMD_QUERY, 0, 0, 0, 0, 0, 524287, -524288, 1, 1, 5, 524287, 524287);
    add_row(nsps_pkg::CMD_WRITE, 63, 100, -50, 100, 50, 0, 0, 0, 0, 0, 0, 0);
    add_row(nsps_pkg::CMD_QUERY, 0, 0, 0, 0, 0, 100, 1000, 0, 0, 0, 0, 0);
    add_row(nsps_pkg::CMD_REMOVE, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(nsps_pkg::CMD_QUERY, 0, 0, 0, 0, 0, 100, 1000, 1, 1, 63, 100, 50);
    add_row(nsps_pkg::CMD_WRITE, 10, 100, -50, 100, 50, 0, 0, 0, 0, 0, 0, 0);
    add_row(nsps_pkg::CMD_QUERY, 0, 0, 0, 0, 0, 100, 1000, 1, 1, 10, 100, 50);
    add_row(nsps_pkg::CMD_REMOVE, 20, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_IGNORED, 10, 1, 2, 3, 4, 5, 6, 0, 0, 0, 0, 0);
    add_row(nsps_pkg::CMD_WRITE, 10, -1000, 0, 1000, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(nsps_pkg::CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 1, 1, 10, 0, 0);
    add_row(nsps_pkg::CMD_WRITE, 1, 0, 100, 160, -60, 0, 0, 0, 0, 0, 0, 0);
    add_row(nsps_pkg::CMD_QUERY, 0, 0, 0, 0, 0, 37, -5, 0, 0, 0, 0, 0);
    add_row(nsps_pkg::CMD_WRITE, 2, 300, 20, -300, -90, 0, 0, 0, 0, 0, 0, 0);
    add_row(nsps_pkg::CMD_QUERY, 0, 0, 0, 0, 0, 77, 500, 0, 0, 0, 0, 0);
    add_row(nsps_pkg::CMD_QUERY, 0, 0, 0, 0, 0, -524288, 524287, 0, 0, 0, 0, 0);
    add_row(nsps_pkg::CMD_REMOVE, 63, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(nsps_pkg::CMD_REMOVE, 10, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(nsps_pkg::CMD_REMOVE, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(nsps_pkg::CMD_REMOVE, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(nsps_pkg::CMD_QUERY, 0, 0, 0, 0, 0, -7, 9, 1, 0, 0, 0, 0);
    foreach (directed_rows[i]) send_word(directed_rows[i]);

    // Random words over several weights, the extremes among them.
    phase_weight = '{8'd255, 8'd1, 8'd0, 8'($urandom_range(1, 255)),
                     nsps_pkg::WEIGHT_RESET};
    for (int ph = 0; ph < 5; ph++) begin
      write_weight(phase_weight[ph]);
      for (int n = 0; n < 74; n++) begin
        if (ph == 2 && n == 37) drain_results();
        send_word(rand_word());
        // Sender gaps, except over one long stretch.
        if (ph != 1 && $urandom_range(0, 99) < 28) begin
          start_i <= 1'b0;
          repeat ($urandom_range(1, 4)) @(posedge clk_i);
        end
      end
    end

    start_i <= 1'b0;
    while (pending_nearest.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0 && pending_nearest.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
